// ===== design/cbgd_pkg.sv =====
`timescale 1ns / 1ps
package cbgd_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned NOW_W         = 32;
  localparam int unsigned LPT_W         = 32;
  localparam int unsigned GEAR_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic [LPT_W-1:0] LPT_RESET = 32'd1000;
  localparam logic [GEAR_W-1:0] GEAR_MAX = 2'd2;  // three gears: 0, 1, 2

  typedef enum logic [1:0] {
    ACT_PROCESS   = 2'd0,
    ACT_HOLD      = 2'd1,
    ACT_CLEAR_RUN = 2'd2,
    ACT_RSVD      = 2'd3
  } cbgd_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_INITIAL_GEAR = 2'd1,
    REG_INITIAL_MODE = 2'd2,
    REG_NONE         = 2'd3
  } cbgd_reg_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [NOW_W-1:0] now_time;
    logic             left_xa;
    logic             left_yb;
    logic             right_xa;
    logic             right_yb;
    logic             left_menu;
    logic             right_menu;
    logic             left_click;
    logic             right_click;
    logic             head_reference_ok;
  } cbgd_in_item_t;

  typedef struct packed {
    logic              abs_mode;
    logic [GEAR_W-1:0] speed_gear;
    logic              mode_flip;
    logic              arm_rst_l;
    logic              arm_rst_r;
    logic              arm_rst_lr;
    logic              joint_reset_request;
    logic              head_rezero;
    logic              gear_changed;
  } cbgd_out_item_t;

  // Per-item controls shared by the four press timers.
  typedef struct packed {
    logic en;         // item advances this cycle
    logic pre_clear;  // clear timers before processing
    logic run;        // evaluate the long-press condition
  } cbgd_tmr_ctl_t;

  function automatic logic [GEAR_W-1:0] cbgd_gear_clamp(input logic [GEAR_W-1:0] g);
    return (g > GEAR_MAX) ? GEAR_MAX : g;
  endfunction

  function automatic logic [GEAR_W-1:0] cbgd_gear_next(input logic [GEAR_W-1:0] g);
    logic [GEAR_W-1:0] c;
    c = cbgd_gear_clamp(g);
    return (c == GEAR_MAX) ? '0 : c + 1'b1;
  endfunction

endpackage

// ===== design/cbgd_if.sv =====
`timescale 1ns / 1ps
interface cbgd_in_if;
  import cbgd_pkg::*;
  logic          valid;
  logic          ready;
  cbgd_in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbgd_out_if;
  import cbgd_pkg::*;
  logic           valid;
  logic           ready;
  cbgd_out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cbgd_press_timer.sv =====
`timescale 1ns / 1ps
module cbgd_press_timer
  import cbgd_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cbgd_tmr_ctl_t        ctl,
  input  logic                 cond,
  input  logic [TIME_BITS-1:0] now,
  input  logic [LPT_W-1:0]     lpt,
  output logic                 fire
);

  localparam int unsigned CMP_W = (TIME_BITS > LPT_W) ? TIME_BITS : LPT_W;

  logic                 active_r, active_nxt;
  logic                 fired_r, fired_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                 act_e, fired_e;
  logic [TIME_BITS-1:0] elapsed;
  logic                 reached;

  assign act_e   = ctl.pre_clear ? 1'b0 : active_r;
  assign fired_e = ctl.pre_clear ? 1'b0 : fired_r;
  assign elapsed = now - start_r;  // wraps modulo 2^TIME_BITS
  assign reached = CMP_W'(elapsed) >= CMP_W'(lpt);

  always_comb begin
    active_nxt = act_e;
    fired_nxt  = fired_e;
    start_nxt  = start_r;
    fire       = 1'b0;
    if (ctl.run) begin
      priority if (!cond) begin
        active_nxt = 1'b0;
        fired_nxt  = 1'b0;
      end else if (!act_e) begin
        active_nxt = 1'b1;
        start_nxt  = now;
      end else if (!fired_e && reached) begin
        fired_nxt = 1'b1;
        fire      = 1'b1;
      end else begin
        fired_nxt = fired_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fired_r  <= 1'b0;
    end else if (ctl.en) begin
      active_r <= active_nxt;
      fired_r  <= fired_nxt;
    end
  end

  // start time is only read while the timer is armed
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      start_r <= start_nxt;
    end
  end

endmodule

// ===== design/controller_button_gesture_decoder.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// in_if   | in  | valid/ready        | cbgd_in_item_t: action, now_time, buttons, clicks
// out_if  | out | valid/ready        | cbgd_out_item_t: mode, gear, event flags
// cfg_*   | in  | cfg_we, no stall   | cfg_index selects register, cfg_wdata 32 bits
//
// One item per cycle sustained while out_if.ready holds; an item's result reaches
// out_if through the input register, then the result register. The single pass
// through the four press timers and the click edge logic lies between the two.
// Synchronous active-low reset: timers idle, click flags clear, gear 0, mode 0,
// long press 1000 ticks. Stalls on out_if back up through the input register;
// in_if.ready stays high while the input register can drain.
module controller_button_gesture_decoder
  import cbgd_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cbgd_in_if.sink               in_if,
  cbgd_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  // Timer slots
  localparam int unsigned T_MODE  = 0;
  localparam int unsigned T_LEFT  = 1;
  localparam int unsigned T_RIGHT = 2;
  localparam int unsigned T_BOTH  = 3;

  // ---------------- configuration ----------------
  logic [LPT_W-1:0]  lpt_r;

  // ---------------- pipeline ----------------
  logic           s1_v_r;
  cbgd_in_item_t  s1_item_r;
  logic           out_v_r;
  cbgd_out_item_t out_item_r, out_item_nxt;
  logic           s2_load, s1_adv, in_acc;

  // ---------------- decoder state ----------------
  logic              prev_lclick_r, prev_rclick_r;
  logic [GEAR_W-1:0] gear_r, gear_nxt;
  logic              mode_r, mode_nxt;

  cbgd_tmr_ctl_t        tctl;
  logic [3:0]           tcond;
  logic [3:0]           tfire;
  logic [EXT_W-1:0]     now_ext;
  logic [TIME_BITS-1:0] now_w;
  logic                 lcombo, rcombo, combo_lr;
  logic                 ledge, redge;

  // Output register frees up when empty or being taken; input register drains into it.
  assign s2_load     = !out_v_r || out_if.ready;
  assign s1_adv      = s1_v_r && s2_load;
  assign in_if.ready = !s1_v_r || s2_load;
  assign in_acc      = in_if.valid && in_if.ready;

  assign out_if.valid = out_v_r;
  assign out_if.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_if.data;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  // ---------------- action decode ----------------
  always_comb begin
    tctl.en = s1_adv;
    unique case (cbgd_action_t'(s1_item_r.action))
      ACT_PROCESS: begin
        tctl.pre_clear = 1'b0;
        tctl.run       = 1'b1;
      end
      ACT_CLEAR_RUN: begin
        tctl.pre_clear = 1'b1;
        tctl.run       = 1'b1;
      end
      ACT_HOLD, ACT_RSVD: begin  // reserved code behaves as hold
        tctl.pre_clear = 1'b1;
        tctl.run       = 1'b0;
      end
      default: begin
        tctl.pre_clear = 1'b1;
        tctl.run       = 1'b0;
      end
    endcase
  end

  // Time stamp resized to the wrap width.
  assign now_ext = EXT_W'(s1_item_r.now_time);
  assign now_w   = now_ext[TIME_BITS-1:0];

  // Both combos held: the mode timer runs in place of the per-side timers; they see a
  // false condition, which clears them.
  assign lcombo   = s1_item_r.left_xa && s1_item_r.left_yb;
  assign rcombo   = s1_item_r.right_xa && s1_item_r.right_yb;
  assign combo_lr = lcombo && rcombo;

  assign tcond[T_MODE]  = combo_lr;
  assign tcond[T_LEFT]  = lcombo && !combo_lr;
  assign tcond[T_RIGHT] = rcombo && !combo_lr;
  assign tcond[T_BOTH]  = s1_item_r.left_menu || s1_item_r.right_menu;

  for (genvar t = 0; t < 4; t++) begin : g_tmr
    cbgd_press_timer #(
      .TIME_BITS(TIME_BITS)
    ) u_tmr (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (tctl),
      .cond  (tcond[t]),
      .now   (now_w),
      .lpt   (lpt_r),
      .fire  (tfire[t])
    );
  end

  // Click edges count only on plain process items; a clear loads the flag
  // from the current click, so no edge is seen on that item.
  assign ledge = tctl.run && !tctl.pre_clear && s1_item_r.left_click && !prev_lclick_r;
  assign redge = tctl.run && !tctl.pre_clear && s1_item_r.right_click && !prev_rclick_r;

  assign mode_nxt = mode_r ^ tfire[T_MODE];
  assign gear_nxt = redge ? cbgd_gear_next(gear_r) : gear_r;

  always_comb begin
    out_item_nxt.abs_mode            = mode_nxt;
    out_item_nxt.speed_gear          = gear_nxt;
    out_item_nxt.mode_flip           = tfire[T_MODE];
    out_item_nxt.arm_rst_l           = tfire[T_LEFT];
    out_item_nxt.arm_rst_r           = tfire[T_RIGHT];
    out_item_nxt.arm_rst_lr          = tfire[T_BOTH];
    out_item_nxt.joint_reset_request = tfire[T_LEFT] || tfire[T_RIGHT] || tfire[T_BOTH];
    out_item_nxt.head_rezero         = ledge && s1_item_r.head_reference_ok;
    out_item_nxt.gear_changed        = redge;
  end

  // ---------------- state and configuration registers ----------------
  // Presets also load the live gear and mode; the user must write only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpt_r         <= LPT_RESET;
      gear_r        <= '0;
      mode_r        <= 1'b0;
      prev_lclick_r <= 1'b0;
      prev_rclick_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        gear_r        <= gear_nxt;
        mode_r        <= mode_nxt;
        prev_lclick_r <= s1_item_r.left_click;
        prev_rclick_r <= s1_item_r.right_click;
      end
      if (cfg_we) begin
        unique case (cbgd_reg_t'(cfg_index))
          REG_LONG_PRESS: begin
            lpt_r <= LPT_W'(cfg_wdata);
          end
          REG_INITIAL_GEAR: begin
            gear_r <= cbgd_gear_clamp(cfg_wdata[GEAR_W-1:0]);
          end
          REG_INITIAL_MODE: begin
            mode_r <= cfg_wdata[0];
          end
          REG_NONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------- assertions ----------------
  // Mode toggle and per-side resets come from exclusive combo conditions.
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_item_r.mode_flip &&
                  (out_item_r.arm_rst_l || out_item_r.arm_rst_r)))
    else $error("mode toggle together with side reset");

  // Gear register never leaves the three legal gears.
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    gear_r <= GEAR_MAX)
    else $error("gear out of range");

  // A hold item produces no events.
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !tctl.run) |=>
      !(out_item_r.mode_flip || out_item_r.joint_reset_request ||
        out_item_r.head_rezero || out_item_r.gear_changed))
    else $error("event on hold item");

  // Mode only changes through a toggle event or a preset write.
  a_mode_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !cfg_we && !tfire[T_MODE]) |=> $stable(mode_r) && (mode_r == $past(mode_r)))
    else $error("mode changed without toggle");

endmodule

// ===== dv/cbgd_gesture_checker.sv =====
`timescale 1ns / 1ps
module cbgd_gesture_checker
  import cbgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cbgd_in_if                    in_ch,
  cbgd_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_ticks
);

  localparam int TMR_MODE  = 0;
  localparam int TMR_LEFT  = 1;
  localparam int TMR_RIGHT = 2;
  localparam int TMR_BOTH  = 3;

  // Shadow of the configuration registers.
  logic [LPT_W-1:0]  press_ticks;
  logic [GEAR_W-1:0] preset_gear;
  logic              preset_mode;

  // Shadow of the decoder state.
  bit                tmr_active [4];
  bit                tmr_fired  [4];
  logic [NOW_W-1:0]  tmr_start  [4];
  bit                last_lclick;
  bit                last_rclick;
  logic [GEAR_W-1:0] gear_now;
  logic              mode_now;

  cbgd_out_item_t expected_ticks[$];

  function automatic logic [GEAR_W-1:0] limit_gear(input logic [GEAR_W-1:0] g);
    return (g > GEAR_MAX) ? GEAR_MAX : g;
  endfunction

  task automatic clear_tmr(input int idx);
    tmr_active[idx] = 1'b0;
    tmr_fired[idx]  = 1'b0;
    tmr_start[idx]  = '0;
  endtask

  // First tick with the condition arms, a later tick fires once the wrapped
  // hold time reaches the threshold.
  task automatic press_timer(input bit cond, input logic [NOW_W-1:0] now, input int idx,
                             output bit fired);
    logic [NOW_W-1:0] held;
    fired = 1'b0;
    held  = now - tmr_start[idx];
    if (!cond) begin
      clear_tmr(idx);
    end else if (!tmr_active[idx]) begin
      tmr_active[idx] = 1'b1;
      tmr_start[idx]  = now;
    end else if (!tmr_fired[idx] && held >= press_ticks) begin
      tmr_fired[idx] = 1'b1;
      fired          = 1'b1;
    end
  endtask

  task automatic decode_tick(input cbgd_in_item_t it, output cbgd_out_item_t r);
    bit lcombo, rcombo, hit;
    logic [GEAR_W-1:0] g;
    r      = '0;
    lcombo = it.left_xa && it.left_yb;
    rcombo = it.right_xa && it.right_yb;
    // hold, clear-and-run and the reserved code all start by clearing
    if (it.action != ACT_PROCESS) begin
      for (int t = 0; t < 4; t++) clear_tmr(t);
      last_lclick = it.left_click;
      last_rclick = it.right_click;
    end
    if (it.action == ACT_PROCESS || it.action == ACT_CLEAR_RUN) begin
      if (lcombo && rcombo) begin
        clear_tmr(TMR_LEFT);
        clear_tmr(TMR_RIGHT);
        press_timer(1'b1, it.now_time, TMR_MODE, hit);
        if (hit) begin
          mode_now    = ~mode_now;
          r.mode_flip = 1'b1;
        end
      end else begin
        clear_tmr(TMR_MODE);
        press_timer(lcombo, it.now_time, TMR_LEFT, hit);
        r.arm_rst_l = hit;
        press_timer(rcombo, it.now_time, TMR_RIGHT, hit);
        r.arm_rst_r = hit;
      end
      press_timer(it.left_menu || it.right_menu, it.now_time, TMR_BOTH, hit);
      r.arm_rst_lr  = hit;
      r.head_rezero = it.left_click && !last_lclick && it.head_reference_ok;
      last_lclick   = it.left_click;
      if (it.right_click && !last_rclick) begin
        g              = limit_gear(gear_now);
        gear_now       = (g == GEAR_MAX) ? '0 : g + 1'b1;
        r.gear_changed = 1'b1;
      end
      last_rclick = it.right_click;
    end
    r.joint_reset_request = r.arm_rst_l || r.arm_rst_r || r.arm_rst_lr;
    r.abs_mode            = mode_now;
    r.speed_gear          = gear_now;
  endtask

  task automatic check_field(input string name, input logic [1:0] exp_v,
                             input logic [1:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    cbgd_out_item_t want, got;
    if (!rst_n) begin
      press_ticks = LPT_RESET;
      preset_gear = '0;
      preset_mode = 1'b0;
      for (int t = 0; t < 4; t++) clear_tmr(t);
      last_lclick = 1'b0;
      last_rclick = 1'b0;
      gear_now    = '0;
      mode_now    = 1'b0;
      expected_ticks.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_PRESS: press_ticks = cfg_wdata[LPT_W-1:0];
          REG_INITIAL_GEAR: begin
            preset_gear = cfg_wdata[GEAR_W-1:0];
            gear_now    = limit_gear(preset_gear);
          end
          REG_INITIAL_MODE: begin
            preset_mode = cfg_wdata[0];
            mode_now    = preset_mode;
          end
          default: ;
        endcase
      end
      // results first: nothing accepted this edge can leave this edge
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_ticks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing expected: %h", $time, got);
        end else begin
          want = expected_ticks.pop_front();
          check_field("abs_mode", want.abs_mode, got.abs_mode);
          check_field("speed_gear", want.speed_gear, got.speed_gear);
          check_field("mode_flip", want.mode_flip, got.mode_flip);
          check_field("arm_rst_l", want.arm_rst_l, got.arm_rst_l);
          check_field("arm_rst_r", want.arm_rst_r, got.arm_rst_r);
          check_field("arm_rst_lr", want.arm_rst_lr, got.arm_rst_lr);
          check_field("joint_reset_request", want.joint_reset_request,
                      got.joint_reset_request);
          check_field("head_rezero", want.head_rezero, got.head_rezero);
          check_field("gear_changed", want.gear_changed, got.gear_changed);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_tick(in_ch.data, want);
        expected_ticks.push_back(want);
      end
    end
    pending_ticks = expected_ticks.size();
  end

endmodule

// ===== dv/tb_controller_button_gesture_decoder.sv =====
`timescale 1ns / 1ps
module tb_controller_button_gesture_decoder;
  import cbgd_pkg::*;

  // Button bits in the order they sit in the item, below action and now_time.
  localparam logic [8:0] BTN_LXA    = 9'b1_0000_0000;
  localparam logic [8:0] BTN_LYB    = 9'b0_1000_0000;
  localparam logic [8:0] BTN_RXA    = 9'b0_0100_0000;
  localparam logic [8:0] BTN_RYB    = 9'b0_0010_0000;
  localparam logic [8:0] BTN_LMENU  = 9'b0_0001_0000;
  localparam logic [8:0] BTN_RMENU  = 9'b0_0000_1000;
  localparam logic [8:0] BTN_LCLK   = 9'b0_0000_0100;
  localparam logic [8:0] BTN_RCLK   = 9'b0_0000_0010;
  localparam logic [8:0] BTN_HEADOK = 9'b0_0000_0001;
  localparam logic [8:0] BTN_LCOMBO = BTN_LXA | BTN_LYB;
  localparam logic [8:0] BTN_RCOMBO = BTN_RXA | BTN_RYB;
  localparam logic [8:0] BTN_BOTH   = BTN_LCOMBO | BTN_RCOMBO;
  localparam logic [8:0] BTN_ALL    = 9'h1FF;

  localparam int RAND_PHASES    = 5;
  localparam int ITEMS_PER_RAND = 120;
  // Worst honest silence is a sender gap behind a result stall plus pipeline
  // draining and register writes; allow far more.
  localparam int STALL_LIMIT    = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    pending_ticks;
  int                    wd_count;
  int                    ticks_sent;
  int                    settings_used;
  bit                    calm;  // final stretch: no idling on either side
  int                    rx_left;

  cbgd_in_if  in_if ();
  cbgd_out_if out_if ();

  controller_button_gesture_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cbgd_gesture_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_if),
    .out_ch         (out_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_ticks  (pending_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure: alternating random runs of ready and stalls,
  // solid ready once the final stretch starts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_left      <= 0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_if.ready <= 1'b0;
      rx_left      <= $urandom_range(1, 15) - 1;
    end else begin
      out_if.ready <= 1'b1;
      rx_left      <= $urandom_range(1, 30) - 1;
    end
  end

  // Watchdog: cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_ticks);
        $display("tb_controller_button_gesture_decoder: errors");
        $finish;
      end
    end
  end

  // Offer one tick, with an optional idle burst first; returns on the edge
  // that takes it, leaving valid high for a back-to-back follower.
  task automatic send_tick(input cbgd_in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    ticks_sent++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drive(input logic [1:0] act, input logic [NOW_W-1:0] now,
                       input logic [8:0] btn);
    send_tick(cbgd_in_item_t'({act, now, btn}));
  endtask

  // Wait for every expected result, then let the pipeline go quiet before
  // any register write. The first edge lets the checker log the last tick.
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Gear and mode writes carry random upper bits, which must be ignored.
  task automatic set_regs(input logic [LPT_W-1:0] lpt, input logic [GEAR_W-1:0] gear,
                          input logic mode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_PRESS;
    cfg_wdata <= lpt;
    @(posedge clk);
    cfg_index <= REG_INITIAL_GEAR;
    cfg_wdata <= {30'($urandom()), gear};
    @(posedge clk);
    cfg_index <= REG_INITIAL_MODE;
    cfg_wdata <= {31'($urandom()), mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly held gestures with random clicks and slowly advancing time, some
  // pure noise, the occasional hold/clear/reserved action and time jump.
  task automatic random_phase(input int count);
    logic [NOW_W-1:0] now;
    logic [8:0]       held_btn;
    logic [8:0]       btn;
    logic [1:0]       act;
    int               hold_left;
    bit               noisy;
    now       = $urandom();
    held_btn  = '0;
    hold_left = 0;
    noisy     = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (hold_left == 0) begin
        hold_left = $urandom_range(1, 15);
        noisy     = 1'b0;
        case ($urandom_range(0, 7))
          0: held_btn = BTN_BOTH;
          1: held_btn = BTN_LCOMBO;
          2: held_btn = BTN_RCOMBO;
          3: held_btn = $urandom_range(0, 1) ? BTN_LMENU : BTN_RMENU;
          4: held_btn = BTN_LCOMBO | BTN_RMENU;
          5: held_btn = BTN_RCOMBO | BTN_LMENU | BTN_RMENU;
          6: held_btn = '0;
          default: noisy = 1'b1;
        endcase
      end
      hold_left--;
      if (noisy) begin
        btn = 9'($urandom());
      end else begin
        btn = held_btn;
        if ($urandom_range(0, 2) == 0) btn = btn | BTN_LCLK;
        if ($urandom_range(0, 2) == 0) btn = btn | BTN_RCLK;
        if ($urandom_range(0, 1) == 0) btn = btn | BTN_HEADOK;
      end
      if ($urandom_range(0, 39) == 0) now = $urandom();
      else now = now + $urandom_range(0, 3);
      case ($urandom_range(0, 19))
        0:       act = ACT_HOLD;
        1:       act = ACT_CLEAR_RUN;
        2:       act = ACT_RSVD;
        default: act = ACT_PROCESS;
      endcase
      drive(act, now, btn);
    end
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_LONG_PRESS;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    calm          = 1'b0;
    ticks_sent    = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Short hold time: each gesture fires, timers rearm, clicks edge.
    set_regs(32'd3, 2'd0, 1'b0);
    drive(ACT_PROCESS,   32'd0,  BTN_BOTH);                 // arm mode timer
    drive(ACT_PROCESS,   32'd2,  BTN_BOTH);
    drive(ACT_PROCESS,   32'd3,  BTN_BOTH);                 // mode toggles
    drive(ACT_PROCESS,   32'd10, BTN_BOTH);                 // fires only once
    drive(ACT_PROCESS,   32'd11, BTN_LCOMBO);
    drive(ACT_PROCESS,   32'd14, BTN_LCOMBO | BTN_RMENU);   // left reset
    drive(ACT_PROCESS,   32'd20, BTN_RMENU);                // both reset
    drive(ACT_PROCESS,   32'd21, BTN_RCOMBO);
    drive(ACT_PROCESS,   32'd25, BTN_RCOMBO | BTN_LCLK | BTN_HEADOK);
    drive(ACT_PROCESS,   32'd26, BTN_LCLK | BTN_RCLK);      // gear edge only
    drive(ACT_PROCESS,   32'd27, '0);
    drive(ACT_PROCESS,   32'd28, BTN_LCLK);                 // edge, head not ok
    drive(ACT_HOLD,      32'd29, BTN_RCLK | BTN_LMENU | BTN_LCOMBO);
    drive(ACT_PROCESS,   32'd30, BTN_RCLK | BTN_LMENU);     // hold ate the edge
    drive(ACT_CLEAR_RUN, 32'd31, BTN_LCLK | BTN_HEADOK | BTN_LMENU);
    drive(ACT_RSVD,      32'd32, BTN_ALL);                  // reserved acts as hold
    drive(ACT_PROCESS,   32'hFFFF_FFFF, BTN_ALL);
    drain();

    // Zero hold time fires on the second tick; gear preset 3 loads as 2.
    set_regs(32'd0, 2'd3, 1'b1);
    drive(ACT_PROCESS, 32'hFFFF_FFFF, BTN_BOTH);
    drive(ACT_PROCESS, 32'hFFFF_FFFF, BTN_BOTH);
    drive(ACT_PROCESS, 32'd0, BTN_LCOMBO);
    drive(ACT_PROCESS, 32'd0, BTN_LCOMBO);
    drive(ACT_PROCESS, 32'd1, BTN_RCLK);                    // gear wraps to 0
    drive(ACT_PROCESS, 32'd2, '0);
    drive(ACT_PROCESS, 32'd3, BTN_RCLK);
    drain();

    // All-ones hold time is only reached by time wrapping to start - 1.
    set_regs(32'hFFFF_FFFF, 2'd2, 1'b0);
    drive(ACT_PROCESS, 32'd5, BTN_LMENU);
    drive(ACT_PROCESS, 32'd4, BTN_LMENU);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_regs((p == 1) ? 32'($urandom()) : 32'($urandom_range(1, 12)),
               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      calm = (p == RAND_PHASES - 1);
      random_phase(ITEMS_PER_RAND);
      drain();
    end

    $display("covered %0d ticks under %0d register settings, hold times 0 to all-ones",
             ticks_sent, settings_used);
    if (mismatch_count == 0)
      $display("tb_controller_button_gesture_decoder: clean");
    else
      $display("tb_controller_button_gesture_decoder: errors");
    $finish;
  end

endmodule
